// ----- rtl/rip_pkg.sv -----
// shared types, constants and tables of the ripening index accumulator
package rip_pkg;

   localparam int TempW  = 16;
   localparam int HumW   = 15;
   localparam int EthW   = 20;
   localparam int CntW   = 12;
   localparam int IdxW   = 15;
   localparam int StageW = 3;
   localparam int VpdW   = 20;
   localparam int DeltaW = 16;
   localparam int WgtW   = 16;

   localparam int MulAW  = 44;
   localparam int MulBW  = 21;
   localparam int MulPW  = MulAW + MulBW;
   localparam int DivNW  = 40;
   localparam int DivDW  = 20;
   localparam int DivCW  = 6;
   localparam int YW     = 24;
   localparam int ExpW   = 44;
   localparam int PolyW  = 32;
   localparam int SumW   = 46;

   localparam logic [IdxW-1:0]   IdxMax    = 15'd25600;
   localparam logic [IdxW-1:0]   IdxReset  = 15'd512;
   localparam logic [HumW-1:0]   HumFull   = 15'd25600;
   localparam logic [VpdW-1:0]   VpdSat    = 20'hFFFFF;
   localparam logic [DeltaW-1:0] DeltaSat  = 16'hFFFF;
   localparam logic [MulBW-1:0]  VpdExpK   = 21'd1632852;
   localparam logic [20:0]       VpdDenOff = 21'd607488;
   localparam logic [MulBW-1:0]  SatPressK = 21'd640449;
   // ceil(2^25 / 25) and (2^22 + 1) / 5, estimates high by at most one
   localparam logic [MulBW-1:0]  VpdRcp    = 21'd1342178;
   localparam logic [MulBW-1:0]  Q10Rcp    = 21'd838861;
   localparam logic signed [YW-1:0] YLow   = -24'sd4194304;
   localparam logic signed [YW-1:0] YHigh  = 24'sd1769472;
   localparam logic [ExpW-1:0]   ExpCap    = 44'h800_0000_0000;
   localparam logic [ExpW-1:0]   ExpOne    = 44'd65536;

   typedef enum logic [2:0] {
      REG_VPD_OPTIMAL   = 3'd0,
      REG_WEIGHT_ETH    = 3'd1,
      REG_WEIGHT_TEMP   = 3'd2,
      REG_WEIGHT_HUM    = 3'd3,
      REG_TEMP_REF      = 3'd4,
      REG_ETH_THRESHOLD = 3'd5,
      REG_SHOCK_WEIGHT  = 3'd6
   } reg_index_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_YV_MUL,
      S_YV_DIV,
      S_YV_WAIT,
      S_EXP_INIT,
      S_EXP_MUL,
      S_EXP_ADD,
      S_EXP_SHIFT,
      S_VS_MUL,
      S_VD_MUL,
      S_VD_DIV,
      S_VD_WAIT,
      S_YQ_MUL,
      S_YQ_DIV,
      S_YQ_WAIT,
      S_TX_MUL,
      S_TX_ACC,
      S_HX_ACC,
      S_SH_ACC,
      S_ET_DIV,
      S_ET_WAIT,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [VpdW-1:0]         vpd_optimal;
      logic [WgtW-1:0]         weight_ethylene;
      logic [WgtW-1:0]         weight_temperature;
      logic [WgtW-1:0]         weight_humidity;
      logic signed [TempW-1:0] temperature_reference;
      logic [EthW-1:0]         ethylene_threshold;
      logic [WgtW-1:0]         shock_weight;
   } cfg_type;

   typedef struct packed {
      logic signed [TempW-1:0] temperature;
      logic [HumW-1:0]         humidity;
      logic [EthW-1:0]         ethylene;
      logic [CntW-1:0]         shock_count;
   } item_type;

   typedef struct packed {
      logic [IdxW-1:0]   ripening_index;
      logic [StageW-1:0] stage;
      logic [VpdW-1:0]   pressure_deficit;
      logic [DeltaW-1:0] index_delta;
   } result_type;

   typedef struct packed {
      logic start;
      logic [DivNW-1:0] dividend;
      logic [DivDW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [DivNW-1:0] quotient;
   } div_rsp_type;

   // 2^f polynomial, q30, ln2^k / k!
   function automatic logic [PolyW-1:0] poly_coef(input logic [2:0] k);
      logic [PolyW-1:0] c;
      case (k)
         3'd0:    c = 32'd1073741824;
         3'd1:    c = 32'd744261118;
         3'd2:    c = 32'd257941248;
         3'd3:    c = 32'd59597083;
         3'd4:    c = 32'd10327387;
         3'd5:    c = 32'd1431680;
         3'd6:    c = 32'd165394;
         default: c = 32'd16377;
      endcase
      return c;
   endfunction

   // log2 of the q10 factor per stage, q16
   function automatic logic [16:0] log2_q10(input logic [StageW-1:0] s);
      logic [16:0] l;
      case (s)
         3'd1:    l = 17'd76672;
         3'd2:    l = 17'd124970;
         3'd3:    l = 17'd103872;
         3'd4:    l = 17'd86633;
         3'd5:    l = 17'd65536;
         3'd6:    l = 17'd55574;
         default: l = 17'd38336;
      endcase
      return l;
   endfunction

   function automatic logic [StageW-1:0] stage_of(input logic [IdxW-1:0] idx);
      logic [StageW-1:0] s;
      s = 3'd1;
      if (idx >= 15'd3584)  s = 3'd2;
      if (idx >= 15'd7168)  s = 3'd3;
      if (idx >= 15'd10752) s = 3'd4;
      if (idx >= 15'd14336) s = 3'd5;
      if (idx >= 15'd17920) s = 3'd6;
      if (idx >= 15'd21760) s = 3'd7;
      return s;
   endfunction

endpackage

// ----- rtl/rip_div.sv -----
// restoring divider, one quotient bit per cycle
module rip_div import rip_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DivDW:0]   rem_ff, rem_in;
   logic [DivNW-1:0] quo_ff, quo_in;
   logic [DivDW-1:0] dsr_ff, dsr_in;
   logic [DivCW-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DivDW:0]   trial;
   logic             fits;

   always_comb begin
      trial   = {rem_ff[DivDW-1:0], quo_ff[DivNW-1]};
      fits    = trial >= {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         dsr_in  = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial - {1'b0, dsr_ff} : trial;
         quo_in = {quo_ff[DivNW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DivCW'(DivNW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ----- rtl/rip_core.sv -----
// sequencer and shared multiplier datapath for one logging interval
module rip_core import rip_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  item_type   item,
   input  cfg_type    cfg,
   input  logic       out_free,
   output logic       idle,
   output logic       done,
   output result_type result
);

   state_type state_ff, state_in;

   logic signed [TempW-1:0] t_ff, t_in;
   logic [HumW-1:0]         hum_ff, hum_in;
   logic [EthW-1:0]         eth_ff, eth_in;
   logic [CntW-1:0]         cnt_ff, cnt_in;
   logic [IdxW-1:0]         idx_ff, idx_in;
   logic [StageW-1:0]       stage_ff, stage_in;
   logic [MulPW-1:0]        mul_ff;
   logic signed [YW-1:0]    y_ff, y_in;
   logic                    neg_ff, neg_in;
   logic                    sel_ff, sel_in;
   logic signed [7:0]       n_ff, n_in;
   logic [15:0]             f_ff, f_in;
   logic [PolyW-1:0]        p_ff, p_in;
   logic [2:0]              k_ff, k_in;
   logic [ExpW-1:0]         e_ff, e_in;
   logic [VpdW-1:0]         vpd_ff, vpd_in;
   logic [SumW-1:0]         sum_ff, sum_in;
   logic [24:0]             rx_ff, rx_in;

   logic [MulAW-1:0]        mul_a;
   logic [MulBW-1:0]        mul_b;
   div_req_type             div_req;
   div_rsp_type             div_rsp;

   logic signed [19:0]      t10;
   logic [18:0]             t10_mag;
   logic [20:0]             den;
   logic signed [16:0]      dt;
   logic [15:0]             dt_mag;
   logic [HumW-1:0]         hum_sat;
   logic [20:0]             vps;
   logic [VpdW-1:0]         vx;
   logic [ExpW-1:0]         excess;
   logic [EthW-1:0]         th;
   logic signed [YW-1:0]    y_div;
   logic [20:0]             vq0;
   logic [25:0]             vq_chk;
   logic [20:0]             vq;
   logic [21:0]             yq0;
   logic [24:0]             yq_chk;
   logic [21:0]             yq;
   logic signed [YW-1:0]    y_q;
   logic                    y_lo, y_hi;
   logic signed [8:0]       sh;
   logic [7:0]              rsh;
   logic [ExpW-1:0]         e_shift;
   logic [37:0]             delta;
   logic [38:0]             nxt;
   logic [IdxW-1:0]         idx_next;

   rip_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      t10     = (20'(t_ff) <<< 3) + (20'(t_ff) <<< 1);
      t10_mag = 19'(t10[19] ? -t10 : t10);
      den     = 21'(t10) + VpdDenOff;
      dt      = 17'(t_ff) - 17'(cfg.temperature_reference);
      dt_mag  = 16'(dt[16] ? -dt : dt);
      hum_sat = (item.humidity > HumFull) ? HumFull : item.humidity;
      vps     = mul_ff[44:24];
      vx      = (vpd_ff > cfg.vpd_optimal) ? vpd_ff - cfg.vpd_optimal : '0;
      excess  = (e_ff > ExpOne) ? e_ff - ExpOne : '0;
      th      = (cfg.ethylene_threshold == '0) ? EthW'(1) : cfg.ethylene_threshold;
      y_div   = neg_ff ? -YW'(div_rsp.quotient) : YW'(div_rsp.quotient);
      // reciprocal estimates, one step down when high
      vq0     = mul_ff[45:25];
      vq_chk  = {1'b0, vq0, 4'b0} + {2'b0, vq0, 3'b0} + 26'(vq0);
      vq      = (vq_chk > 26'(rx_ff)) ? vq0 - 21'd1 : vq0;
      yq0     = mul_ff[43:22];
      yq_chk  = {1'b0, yq0, 2'b0} + 25'(yq0);
      yq      = (yq_chk > rx_ff) ? yq0 - 22'd1 : yq0;
      y_q     = neg_ff ? -YW'(yq) : YW'(yq);
      y_lo    = y_ff < YLow;
      y_hi    = y_ff >= YHigh;
      sh      = 9'(n_ff) - 9'sd14;
      rsh     = 8'(-sh);
      if (!sh[8])
         e_shift = {12'b0, p_ff} << sh[3:0];
      else if (rsh >= 8'd32)
         e_shift = '0;
      else
         e_shift = {12'b0, p_ff >> rsh[4:0]};
      delta    = sum_ff[SumW-1:8];
      nxt      = 39'(idx_ff) + 39'(delta);
      idx_next = (nxt > 39'(IdxMax)) ? IdxMax : nxt[IdxW-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (start) state_in = S_YV_MUL;
         S_YV_MUL:    state_in = S_YV_DIV;
         S_YV_DIV:    state_in = S_YV_WAIT;
         S_YV_WAIT:   if (div_rsp.done) state_in = S_EXP_INIT;
         S_EXP_INIT: begin
            if (y_lo || y_hi) state_in = sel_ff ? S_TX_MUL : S_VS_MUL;
            else state_in = S_EXP_MUL;
         end
         S_EXP_MUL:   state_in = S_EXP_ADD;
         S_EXP_ADD:   state_in = (k_ff == 3'd0) ? S_EXP_SHIFT : S_EXP_MUL;
         S_EXP_SHIFT: state_in = sel_ff ? S_TX_MUL : S_VS_MUL;
         S_VS_MUL:    state_in = S_VD_MUL;
         S_VD_MUL:    state_in = S_VD_DIV;
         S_VD_DIV:    state_in = S_VD_WAIT;
         S_VD_WAIT:   state_in = S_YQ_MUL;
         S_YQ_MUL:    state_in = S_YQ_DIV;
         S_YQ_DIV:    state_in = S_YQ_WAIT;
         S_YQ_WAIT:   state_in = S_EXP_INIT;
         S_TX_MUL:    state_in = S_TX_ACC;
         S_TX_ACC:    state_in = S_HX_ACC;
         S_HX_ACC:    state_in = S_SH_ACC;
         S_SH_ACC:    state_in = S_ET_DIV;
         S_ET_DIV:    state_in = S_ET_WAIT;
         S_ET_WAIT:   if (div_rsp.done) state_in = S_FINISH;
         S_FINISH:    if (out_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // datapath actions
   always_comb begin
      t_in     = t_ff;
      hum_in   = hum_ff;
      eth_in   = eth_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      stage_in = stage_ff;
      y_in     = y_ff;
      neg_in   = neg_ff;
      sel_in   = sel_ff;
      n_in     = n_ff;
      f_in     = f_ff;
      p_in     = p_ff;
      k_in     = k_ff;
      e_in     = e_ff;
      vpd_in   = vpd_ff;
      sum_in   = sum_ff;
      rx_in    = rx_ff;
      mul_a    = '0;
      mul_b    = '0;
      div_req  = '0;
      idle     = 1'b0;
      done     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            idle = 1'b1;
            if (start) begin
               t_in     = item.temperature;
               hum_in   = hum_sat;
               eth_in   = item.ethylene;
               cnt_in   = item.shock_count;
               stage_in = stage_of(idx_ff);
            end
         end
         S_YV_MUL: begin
            mul_a  = MulAW'(t10_mag);
            mul_b  = VpdExpK;
            neg_in = t10[19];
            sel_in = 1'b0;
         end
         S_YV_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = mul_ff[DivNW-1:0];
            div_req.divisor  = den[DivDW-1:0];
         end
         S_YV_WAIT: begin
            if (div_rsp.done) y_in = y_div;
         end
         S_EXP_INIT: begin
            n_in = 8'(y_ff >>> 16);
            f_in = y_ff[15:0];
            p_in = poly_coef(3'd7);
            k_in = 3'd6;
            if (y_lo) e_in = '0;
            else if (y_hi) e_in = ExpCap;
         end
         S_EXP_MUL: begin
            mul_a = MulAW'(p_ff);
            mul_b = MulBW'(f_ff);
         end
         S_EXP_ADD: begin
            p_in = poly_coef(k_ff) + mul_ff[16 +: PolyW];
            k_in = k_ff - 3'd1;
         end
         S_EXP_SHIFT: e_in = e_shift;
         S_VS_MUL: begin
            mul_a = e_ff;
            mul_b = SatPressK;
         end
         S_VD_MUL: begin
            mul_a = MulAW'(vps);
            mul_b = MulBW'(HumFull - hum_ff);
         end
         S_VD_DIV: begin
            // divide by 25600 as a shift by 10 and a divide by 25
            rx_in = mul_ff[34:10];
            mul_a = MulAW'(mul_ff[34:10]);
            mul_b = VpdRcp;
         end
         S_VD_WAIT: begin
            vpd_in = (vq > 21'(VpdSat)) ? VpdSat : vq[VpdW-1:0];
         end
         S_YQ_MUL: begin
            mul_a  = MulAW'(dt_mag);
            mul_b  = MulBW'(log2_q10(stage_ff));
            neg_in = dt[16];
            sel_in = 1'b1;
         end
         S_YQ_DIV: begin
            // divide by 2560 as a shift by 9 and a divide by 5
            rx_in = 25'(mul_ff[32:9]);
            mul_a = MulAW'(mul_ff[32:9]);
            mul_b = Q10Rcp;
         end
         S_YQ_WAIT: y_in = y_q;
         S_TX_MUL: begin
            mul_a = excess;
            mul_b = MulBW'(cfg.weight_temperature);
         end
         S_TX_ACC: begin
            sum_in = SumW'(mul_ff >> 16);
            mul_a  = MulAW'(vx);
            mul_b  = MulBW'(cfg.weight_humidity);
         end
         S_HX_ACC: begin
            sum_in = sum_ff + SumW'(mul_ff >> 12);
            mul_a  = MulAW'(cnt_ff);
            mul_b  = MulBW'(cfg.shock_weight);
         end
         S_SH_ACC: begin
            sum_in = sum_ff + (SumW'(mul_ff) << 8);
            mul_a  = MulAW'(eth_ff);
            mul_b  = MulBW'(cfg.weight_ethylene);
         end
         S_ET_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = mul_ff[DivNW-1:0];
            div_req.divisor  = th;
         end
         S_ET_WAIT: begin
            if (div_rsp.done) sum_in = sum_ff + SumW'(div_rsp.quotient);
         end
         S_FINISH: begin
            if (out_free) begin
               done   = 1'b1;
               idx_in = idx_next;
            end
         end
         default: ;
      endcase
   end

   assign result.ripening_index   = idx_next;
   assign result.stage            = stage_ff;
   assign result.pressure_deficit = vpd_ff;
   assign result.index_delta      = (delta > 38'(DeltaSat)) ? DeltaSat : delta[DeltaW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= IdxReset;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
      t_ff     <= t_in;
      hum_ff   <= hum_in;
      eth_ff   <= eth_in;
      cnt_ff   <= cnt_in;
      stage_ff <= stage_in;
      mul_ff   <= mul_a * mul_b;
      y_ff     <= y_in;
      neg_ff   <= neg_in;
      sel_ff   <= sel_in;
      n_ff     <= n_in;
      f_ff     <= f_in;
      p_ff     <= p_in;
      k_ff     <= k_in;
      e_ff     <= e_in;
      vpd_ff   <= vpd_in;
      sum_ff   <= sum_in;
      rx_ff    <= rx_in;
   end

endmodule

// ----- rtl/ripening_index_accumulator.sv -----
// top level: stream ports, register file and result register
//
//   channel   dir   handshake             payload
//   req_      in    req_tvalid/tready     req_tdata  (64 bits)
//   rsp_      out   rsp_tvalid/tready     rsp_tdata  (56 bits)
//   csr_      in    csr_valid/ready       csr_index, csr_data
//
// one beat makes two passes of the shared divider and two exp2 runs of seven
// horner steps, each run skipped when its exponent saturates, with all products
// on the one shared multiplier
// reset restores the register defaults and an index of 2.0
// req_tready is high only while the sequencer idles; a stalled result holds
// the sequencer in its last step, so no beat enters until the result register frees
module ripening_index_accumulator import rip_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // temperature, humidity, ethylene, shock_count, zero pad
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // ripening_index, stage, pressure_deficit, index_delta, zero pad
   output logic [55:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_data
);

   cfg_type    cfg_ff, cfg_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   item_type   item;
   result_type result;
   logic       idle, done, out_free, start;

   assign item.temperature = req_tdata[15:0];
   assign item.humidity    = req_tdata[30:16];
   assign item.ethylene    = req_tdata[50:31];
   assign item.shock_count = req_tdata[62:51];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = idle;
   assign start      = req_tvalid && idle;
   assign csr_ready  = 1'b1;

   rip_core u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .item     (item),
      .cfg      (cfg_ff),
      .out_free (out_free),
      .idle     (idle),
      .done     (done),
      .result   (result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_VPD_OPTIMAL:   cfg_in.vpd_optimal           = csr_data;
            REG_WEIGHT_ETH:    cfg_in.weight_ethylene       = csr_data[WgtW-1:0];
            REG_WEIGHT_TEMP:   cfg_in.weight_temperature    = csr_data[WgtW-1:0];
            REG_WEIGHT_HUM:    cfg_in.weight_humidity       = csr_data[WgtW-1:0];
            REG_TEMP_REF:      cfg_in.temperature_reference = csr_data[TempW-1:0];
            REG_ETH_THRESHOLD: cfg_in.ethylene_threshold    = csr_data;
            REG_SHOCK_WEIGHT:  cfg_in.shock_weight          = csr_data[WgtW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vpd_optimal           <= 20'd475;
         cfg_ff.weight_ethylene       <= 16'd2621;
         cfg_ff.weight_temperature    <= 16'd5243;
         cfg_ff.weight_humidity       <= 16'd655;
         cfg_ff.temperature_reference <= 16'sd3328;
         cfg_ff.ethylene_threshold    <= 20'd1600;
         cfg_ff.shock_weight          <= 16'd768;
         rsp_valid_ff                 <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.index_delta, rsp_ff.pressure_deficit,
                        rsp_ff.stage, rsp_ff.ripening_index};

endmodule

// ----- rtl/rip_checker.sv -----
// port level checks of the ripening index accumulator and their binding
module rip_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [2:0]  csr_index,
   input logic [19:0] csr_data
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // an accepted beat keeps the block busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accept");

   // stage is never zero
   a_stage: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[17:15] != 3'd0)
      else $error("stage zero");

   // index stays clamped
   a_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[14:0] <= 15'd25600)
      else $error("index above 100");

endmodule

bind ripening_index_accumulator rip_checker u_rip_checker (.*);
